### hdl/assert_macros.svh
// Assertion helpers, included by multi_channel_bin_accumulator.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check on every clock edge, reset included.
`define ASSERT_ALL(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/mcba_pkg.sv
package mcba_pkg;

  localparam int KEY_W      = 32;
  localparam int SCALE_W    = 32;
  localparam int SCALE_FRAC = 24;
  localparam int LIMIT_W    = 11;
  localparam int BINSEL_W   = 11;
  localparam int SAMPLE_W   = 32;
  localparam int CONT_W     = 48;
  localparam int USED_W     = 10;
  localparam int CHAN_W     = 2;
  localparam int REQ_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int PROD_W     = KEY_W + SCALE_W;
  localparam int BIN_FULL_W = PROD_W - SCALE_FRAC;

  localparam logic signed [KEY_W-1:0] HIST_MIN_RST    = 32'sd0;
  localparam logic [SCALE_W-1:0]      BIN_SCALE_RST   = 32'd16777216;
  localparam logic [LIMIT_W-1:0]      BINS_IN_USE_RST = 11'd1024;

  localparam logic signed [CONT_W-1:0] CONT_MAX = {1'b0, {(CONT_W-1){1'b1}}};
  localparam logic signed [CONT_W-1:0] CONT_MIN = {1'b1, {(CONT_W-1){1'b0}}};

  typedef enum logic [REQ_W-1:0] {
    REQ_ADD  = 2'd0,
    REQ_MAX  = 2'd1,
    REQ_MIN  = 2'd2,
    REQ_READ = 2'd3
  } req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HIST_MIN    = 2'd0,
    CFG_BIN_SCALE   = 2'd1,
    CFG_BINS_IN_USE = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_CHECK,
    ST_READ,
    ST_WRITE
  } state_t;

  typedef struct packed {
    req_t                       req;
    logic signed [SAMPLE_W-1:0] sample;
  } upd_cmd_t;

endpackage

### hdl/mcba_update.sv
module mcba_update (
  input  mcba_pkg::upd_cmd_t                  cmd,
  input  logic signed [mcba_pkg::CONT_W-1:0]  cur,
  output logic signed [mcba_pkg::CONT_W-1:0]  nxt
);
  import mcba_pkg::*;

  logic signed [CONT_W:0]   sum;
  logic signed [CONT_W-1:0] sample_ext;

  assign sample_ext = {{(CONT_W-SAMPLE_W){cmd.sample[SAMPLE_W-1]}}, cmd.sample};
  assign sum        = {cur[CONT_W-1], cur} + {sample_ext[CONT_W-1], sample_ext};

  always_comb begin
    case (cmd.req)
      REQ_ADD: begin
        // clamp when the carry disagrees with the sign
        if (sum[CONT_W] != sum[CONT_W-1]) begin
          nxt = sum[CONT_W] ? CONT_MIN : CONT_MAX;
        end else begin
          nxt = sum[CONT_W-1:0];
        end
      end
      REQ_MAX:  nxt = (sample_ext > cur) ? sample_ext : cur;
      REQ_MIN:  nxt = (sample_ext < cur) ? sample_ext : cur;
      default:  nxt = cur;
    endcase
  end

endmodule

### hdl/multi_channel_bin_accumulator.sv
// Histogram bin accumulator over several channels of 48-bit signed bins.
// Input stream: tuser carries the request kind and the by-index flag, tdata
// the key, bin number, sample and channel. Each request picks a bin either
// directly or as floor((key - hist_min) * bin_scale / 2^24), then adds the
// sample (saturating), keeps the larger or smaller value, or only reads.
// Output stream: one beat per request with the accepted flag in tuser and
// the bin index and new bin content in tdata; rejected requests return zero.
// Configuration: cfg_valid/cfg_index/cfg_data writes hist_min, bin_scale or
// bins_in_use; cfg_ready is always high. Write only while no request is open.
// Steps: each accepted request goes through multiply, range check, read and
// write back of the bin memory; no new request is taken until the last one
// has been written back.
// Reset: a clearing pass writes zero into every memory entry (4096 by default),
// one a cycle; in_tready stays low until it ends. A stalled result holds in
// the output register; the next request is still taken and waits before
// write back until the output register frees up.
module multi_channel_bin_accumulator #(
  parameter int NUM_BINS     = 1024,
  parameter int NUM_CHANNELS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,   // key_value[31:0], bin_number[42:32],
                                  // sample_value[74:43], channel[76:75], zero pad
  input  logic [2:0]  in_tuser,   // req_type[1:0], by_index[2]
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // bin_used[9:0], bin_content[57:10], zero pad
  output logic [0:0]  out_tuser,  // accepted[0]
  // configuration writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [mcba_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [31:0]                      cfg_data
);
  import mcba_pkg::*;

  `include "assert_macros.svh"

  localparam int BIN_AW = $clog2(NUM_BINS);
  localparam int CH_AW  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int AW     = BIN_AW + CH_AW;
  localparam int DEPTH  = 1 << AW;
  localparam int LIM_W  = ($clog2(NUM_BINS + 1) > LIMIT_W) ? $clog2(NUM_BINS + 1) : LIMIT_W;
  localparam int CHK_W  = 8;

  // configuration
  logic signed [KEY_W-1:0] hist_min_r;
  logic [SCALE_W-1:0]      bin_scale_r;
  logic [LIMIT_W-1:0]      bins_in_use_r;

  // input fields
  req_t                       in_req;
  logic                       in_by_index;
  logic signed [KEY_W-1:0]    in_key;
  logic [BINSEL_W-1:0]        in_binsel;
  logic signed [SAMPLE_W-1:0] in_sample;
  logic [CHAN_W-1:0]          in_chan;
  logic signed [KEY_W:0]      diff_nxt;

  // request pipeline
  state_t                     state_r, state_nxt;
  req_t                       req_r;
  logic                       by_index_r;
  logic                       neg_r;
  logic [KEY_W-1:0]           diff_r;
  logic [BINSEL_W-1:0]        binsel_r;
  logic signed [SAMPLE_W-1:0] sample_r;
  logic [CHAN_W-1:0]          chan_r;
  logic [PROD_W-1:0]          prod_r;
  logic                       hit_r;
  logic [AW-1:0]              addr_r;
  logic [USED_W-1:0]          used_r;
  logic [AW-1:0]              clr_r;

  logic [BIN_FULL_W-1:0]      bin_full;
  logic [LIM_W-1:0]           limit;
  logic                       key_ok;
  logic                       chan_ok;
  logic                       hit_nxt;

  // memory
  logic signed [CONT_W-1:0]   mem [DEPTH];
  logic signed [CONT_W-1:0]   rd_data_r;
  logic                       mem_we;
  logic [AW-1:0]              mem_wa;
  logic signed [CONT_W-1:0]   mem_wd;
  logic signed [CONT_W-1:0]   upd_value;
  upd_cmd_t                   upd_cmd;

  // output register
  logic                       out_valid_r;
  logic                       out_accepted_r;
  logic [USED_W-1:0]          out_used_r;
  logic signed [CONT_W-1:0]   out_content_r;

  logic in_fire;
  logic out_free;
  logic ld_out;
  logic rd_en;

  assign in_req      = req_t'(in_tuser[1:0]);
  assign in_by_index = in_tuser[2];
  assign in_key      = in_tdata[31:0];
  assign in_binsel   = in_tdata[42:32];
  assign in_sample   = in_tdata[74:43];
  assign in_chan     = in_tdata[76:75];

  assign cfg_ready = 1'b1;
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  assign diff_nxt = {in_key[KEY_W-1], in_key} - {hist_min_r[KEY_W-1], hist_min_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_min_r    <= HIST_MIN_RST;
      bin_scale_r   <= BIN_SCALE_RST;
      bins_in_use_r <= BINS_IN_USE_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_HIST_MIN) begin
        hist_min_r <= cfg_data;
      end
      if (cfg_index == CFG_BIN_SCALE) begin
        bin_scale_r <= cfg_data;
      end
      if (cfg_index == CFG_BINS_IN_USE) begin
        bins_in_use_r <= cfg_data[LIMIT_W-1:0];
      end
    end
  end

  // range check
  always_comb begin
    bin_full = by_index_r ? BIN_FULL_W'(binsel_r) : prod_r[PROD_W-1:SCALE_FRAC];
    limit    = (LIM_W'(bins_in_use_r) < LIM_W'(NUM_BINS)) ? LIM_W'(bins_in_use_r)
                                                          : LIM_W'(NUM_BINS);
    // zero scale maps every key, even one below hist_min, to bin zero
    key_ok   = by_index_r || (bin_scale_r == '0) || !neg_r;
    chan_ok  = CHK_W'(chan_r) < CHK_W'(NUM_CHANNELS);
    hit_nxt  = key_ok && chan_ok && (bin_full < BIN_FULL_W'(limit));
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (&clr_r) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_tvalid) state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_CHECK;
      ST_CHECK: state_nxt = ST_READ;
      ST_READ:  state_nxt = ST_WRITE;
      ST_WRITE: if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  // state outputs
  always_comb begin
    in_tready = 1'b0;
    rd_en     = 1'b0;
    ld_out    = 1'b0;
    mem_we    = 1'b0;
    mem_wa    = addr_r;
    mem_wd    = upd_value;
    case (state_r)
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_r;
        mem_wd = '0;
      end
      ST_IDLE:  in_tready = 1'b1;
      ST_READ:  rd_en = 1'b1;
      ST_WRITE: begin
        ld_out = out_free;
        mem_we = out_free && hit_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_r <= clr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_r      <= in_req;
      by_index_r <= in_by_index;
      neg_r      <= diff_nxt[KEY_W];
      diff_r     <= diff_nxt[KEY_W-1:0];
      binsel_r   <= in_binsel;
      sample_r   <= in_sample;
      chan_r     <= in_chan;
    end
    if (state_r == ST_MUL) begin
      prod_r <= {{(PROD_W-KEY_W){1'b0}}, diff_r} * {{(PROD_W-SCALE_W){1'b0}}, bin_scale_r};
    end
    if (state_r == ST_CHECK) begin
      hit_r  <= hit_nxt;
      addr_r <= {CH_AW'(chan_r), bin_full[BIN_AW-1:0]};
      used_r <= bin_full[USED_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      rd_data_r <= mem[addr_r];
    end
  end

  assign upd_cmd.req    = req_r;
  assign upd_cmd.sample = sample_r;

  mcba_update u_update (
    .cmd (upd_cmd),
    .cur (rd_data_r),
    .nxt (upd_value)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ld_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_out) begin
      out_accepted_r <= hit_r;
      out_used_r     <= hit_r ? used_r : '0;
      out_content_r  <= hit_r ? upd_value : '0;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tuser[0] = out_accepted_r;
  assign out_tdata    = {6'b0, out_content_r, out_used_r};

  `ASSERT_CLK(a_we_state, mem_we |-> (state_r == ST_WRITE || state_r == ST_CLEAR),
    "bin memory written outside clear or write back")
  `ASSERT_CLK(a_ld_free, ld_out |-> (!out_valid_r || out_tready),
    "output register overwritten while a result waits")
  `ASSERT_CLK(a_fire_mul, in_fire |=> (state_r == ST_MUL),
    "accepted request did not enter the multiply step")
  `ASSERT_CLK(a_reject_zero, (out_valid_r && !out_accepted_r) |-> (out_tdata == '0),
    "rejected request returned nonzero data")
  `ASSERT_ALL(a_clear_no_in, (state_r == ST_CLEAR) |-> !in_tready,
    "input taken during the clearing pass")

endmodule

### dv/multi_channel_bin_accumulator_tb.sv
module multi_channel_bin_accumulator_tb;
  import mcba_pkg::*;

  localparam int STORE_BINS  = 1024;
  localparam int STALL_LIMIT = 20000;
  localparam int HOLD_CYCLES = 300;
  localparam int SAT_STEPS   = 24;

  localparam longint KEY_LO = -64'sd2147483648;
  localparam longint KEY_HI = 64'sd2147483647;
  localparam int     S_MAX  = 32'h7fff_ffff;
  localparam int     S_MIN  = 32'h8000_0000;

  typedef struct {
    req_t              req;
    bit                by_idx;
    logic signed [31:0] key;
    logic [10:0]       binsel;
    logic signed [31:0] sample;
    logic [1:0]        chan;
  } bin_req_t;

  typedef struct {
    bit                 accepted;
    logic [9:0]         bin;
    logic signed [47:0] content;
  } bin_result_t;

  logic        clk;
  logic        rst_n     = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [79:0] in_tdata  = '0;
  logic [2:0]  in_tuser  = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic [0:0]  out_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_HIST_MIN;
  logic [31:0] cfg_data = '0;

  multi_channel_bin_accumulator u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // shadow of the block's registers and bin store
  logic signed [31:0] p_hist_min    = HIST_MIN_RST;
  logic [31:0]        p_bin_scale   = BIN_SCALE_RST;
  logic [10:0]        p_bins_in_use = BINS_IN_USE_RST;
  logic signed [47:0] bin_mem [4][STORE_BINS];

  bin_req_t    req_backlog[$];
  bin_result_t bin_results_due[$];
  bin_req_t    offered_req;

  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int rx_hold_req  = 0;
  int rx_hold_seen = 0;
  int rx_hold_left = 0;
  int errors       = 0;
  int idle_cycles  = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    foreach (bin_mem[c, b]) bin_mem[c][b] = '0;
  end

  function automatic bin_result_t bin_update(bin_req_t r);
    bin_result_t res;
    longint      diff;
    logic [63:0] udiff;
    logic [63:0] bin;
    longint      cur;
    longint      samp;
    bit          hit;
    int          lim;
    res  = '{0, '0, '0};
    hit  = 1'b1;
    bin  = '0;
    lim  = (int'(p_bins_in_use) < STORE_BINS) ? int'(p_bins_in_use) : STORE_BINS;
    if (r.by_idx) begin
      bin = 64'(r.binsel);
    end else if (p_bin_scale != 0) begin
      diff = longint'(r.key) - longint'(p_hist_min);
      if (diff < 0) begin
        hit = 1'b0;
      end else begin
        udiff = diff;
        bin   = (udiff * {32'b0, p_bin_scale}) >> SCALE_FRAC;
      end
    end
    if (!hit || bin >= lim) return res;
    cur  = longint'(bin_mem[r.chan][bin[9:0]]);
    samp = longint'(r.sample);
    case (r.req)
      REQ_ADD: begin
        cur = cur + samp;
        if (cur > longint'(CONT_MAX)) cur = longint'(CONT_MAX);
        if (cur < longint'(CONT_MIN)) cur = longint'(CONT_MIN);
      end
      REQ_MAX: if (samp > cur) cur = samp;
      REQ_MIN: if (samp < cur) cur = samp;
      default: ;
    endcase
    bin_mem[r.chan][bin[9:0]] = cur[47:0];
    res.accepted = 1'b1;
    res.bin      = bin[9:0];
    res.content  = cur[47:0];
    return res;
  endfunction

  // Bias toward keys and indexes that land in range, often on a few hot bins.
  function automatic bin_req_t rand_req();
    bin_req_t r;
    int       sel;
    int       lim;
    int       hot;
    int       tgt;
    longint   diff;
    longint   k;
    r.req    = req_t'($urandom_range(3));
    r.chan   = 2'($urandom_range(3));
    r.binsel = 11'($urandom_range(2047));
    r.key    = $urandom;
    r.by_idx = 1'b0;
    lim = (int'(p_bins_in_use) > STORE_BINS) ? STORE_BINS : int'(p_bins_in_use);
    if (lim == 0) lim = 1;
    hot = (lim > 8) ? 7 : lim - 1;
    tgt = $urandom_range(1) ? $urandom_range(hot) : $urandom_range(lim);
    sel = $urandom_range(99);
    if (sel < 40) begin
      r.by_idx = 1'b1;
      if ($urandom_range(4) != 0) r.binsel = 11'(tgt);
    end else if (sel < 85 && p_bin_scale != 0) begin
      diff = ((longint'(tgt) << SCALE_FRAC) + $urandom_range(24'hff_ffff)) / p_bin_scale;
      k    = longint'(p_hist_min) + diff;
      if (k >= KEY_LO && k <= KEY_HI) r.key = k[31:0];
    end
    case ($urandom_range(3))
      1: r.sample = $urandom_range(200) - 100;
      2: r.sample = $urandom_range(1) ? S_MAX : S_MIN;
      default: r.sample = $urandom;
    endcase
    return r;
  endfunction

  task automatic push_req(req_t rq, bit bi, int key, int bnum, int samp, int ch);
    bin_req_t r;
    r.req    = rq;
    r.by_idx = bi;
    r.key    = key;
    r.binsel = 11'(bnum);
    r.sample = samp;
    r.chan   = 2'(ch);
    req_backlog.push_back(r);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (req_backlog.size() != 0 || in_tvalid || bin_results_due.size() != 0);
  endtask

  task automatic cfg_write(cfg_idx_t idx, logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_HIST_MIN:    p_hist_min    = val;
      CFG_BIN_SCALE:   p_bin_scale   = val;
      CFG_BINS_IN_USE: p_bins_in_use = val[10:0];
      default: ;
    endcase
  endtask

  // request driver: predict on each accepted beat, hold the offer until taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) bin_results_due.push_back(bin_update(offered_req));
      if (!in_tvalid || in_tready) begin
        if (req_backlog.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          offered_req = req_backlog.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {3'b0, offered_req.chan, offered_req.sample,
                        offered_req.binsel, offered_req.key};
          in_tuser  <= {offered_req.by_idx, offered_req.req};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result receiver: random stalls plus one long hold on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (rx_hold_left > 0) begin
      out_tready   <= 1'b0;
      rx_hold_left <= rx_hold_left - 1;
    end else if (rx_hold_req != rx_hold_seen) begin
      out_tready   <= 1'b0;
      rx_hold_seen <= rx_hold_req;
      rx_hold_left <= HOLD_CYCLES;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    bin_result_t        e;
    logic signed [47:0] got_cont;
    if (rst_n && out_tvalid && out_tready) begin
      got_cont = out_tdata[57:10];
      if (bin_results_due.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing pending: acc=%0d bin=%0d content=%0d",
                 $time, out_tuser[0], out_tdata[9:0], got_cont);
      end else begin
        e = bin_results_due.pop_front();
        if (out_tuser[0] !== e.accepted || out_tdata[9:0] !== e.bin ||
            got_cont !== e.content) begin
          errors++;
          $display({"%0t: bin result: expected acc=%0d bin=%0d content=%0d, ",
                    "got acc=%0d bin=%0d content=%0d"},
                   $time, e.accepted, e.bin, e.content, out_tuser[0], out_tdata[9:0], got_cont);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
      $display("multi_channel_bin_accumulator: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [31:0] hm;
    logic [31:0] sc;
    logic [10:0] biu;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: hist_min 0, one bin per key unit, 1024 bins
    push_req(REQ_ADD,  0, 0,     0,    5,     0);
    push_req(REQ_MAX,  0, 0,     0,    100,   0);
    push_req(REQ_MIN,  0, 0,     0,    -7,    0);
    push_req(REQ_READ, 0, 0,     0,    0,     0);
    push_req(REQ_ADD,  0, 1023,  0,    S_MAX, 1);
    push_req(REQ_ADD,  0, 1024,  0,    1,     1);
    push_req(REQ_MAX,  0, -1,    0,    1,     1);
    push_req(REQ_READ, 0, S_MIN, 0,    0,     2);
    push_req(REQ_READ, 0, S_MAX, 2047, 0,     3);
    push_req(REQ_READ, 1, 0,     1023, 0,     3);
    push_req(REQ_ADD,  1, 0,     1024, 5,     3);
    push_req(REQ_ADD,  1, S_MIN, 2047, S_MIN, 3);
    push_req(REQ_MAX,  1, 0,     0,    S_MIN, 2);
    push_req(REQ_MIN,  1, 0,     0,    S_MIN, 2);
    push_req(REQ_ADD,  1, 0,     0,    S_MIN, 2);
    push_req(REQ_READ, 1, 0,     0,    0,     2);
    push_req(REQ_MAX,  1, -1,    1023, S_MAX, 3);
    push_req(REQ_ADD,  0, 1023,  0,    S_MAX, 1);
    push_req(REQ_ADD,  0, 1023,  0,    S_MAX, 1);
    push_req(REQ_MIN,  0, 1023,  0,    -1,    1);
    push_req(REQ_READ, 1, 0,     1023, 0,     1);
    wait_drained();

    // pile full-scale samples onto two bins, then back off them
    for (int i = 0; i < SAT_STEPS; i++) push_req(REQ_ADD, 1, 0, 500, S_MAX, 3);
    push_req(REQ_ADD,  1, 0, 500, S_MIN, 3);
    push_req(REQ_READ, 1, 0, 500, 0,     3);
    for (int i = 0; i < SAT_STEPS; i++) push_req(REQ_ADD, 1, 0, 501, S_MIN, 2);
    push_req(REQ_ADD,  1, 0, 501, S_MAX, 2);
    wait_drained();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin hm = 32'd0;          sc = 32'h0100_0000; biu = 11'd1024; end
        1: begin hm = 32'h8000_0000;  sc = 32'hffff_ffff; biu = 11'd1;    end
        2: begin hm = 32'h7fff_ffff;  sc = 32'd0;         biu = 11'd2047; end
        3: begin hm = $urandom; sc = $urandom_range(32'h0400_0000, 32'h0040_0000);
                 biu = 11'($urandom_range(1024, 1)); end
        4: begin hm = $urandom;       sc = $urandom;      biu = 11'd0;    end
        5: begin hm = -32'sd1000;     sc = 32'h0010_0000; biu = 11'd64;   end
        6: begin hm = $urandom; sc = $urandom_range(32'h1000_0000, 1);
                 biu = 11'($urandom_range(1024, 1)); end
        default: begin hm = 32'd0;    sc = 32'h0400_0000; biu = 11'd1000; end
      endcase
      wait_drained();
      repeat (8) @(negedge clk);
      cfg_write(CFG_HIST_MIN, hm);
      cfg_write(CFG_BIN_SCALE, sc);
      cfg_write(CFG_BINS_IN_USE, {21'b0, biu});
      @(negedge clk);
      case (p % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 48; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 48; end
        default: begin tx_idle_pct = 25; rx_stall_pct = 25; end
      endcase
      for (int i = 0; i < 56; i++) req_backlog.push_back(rand_req());
      // back up the output while requests keep coming
      if (p == 0) rx_hold_req++;
      wait_drained();
      for (int i = 0; i < 56; i++) req_backlog.push_back(rand_req());
    end

    wait_drained();
    repeat (8) @(negedge clk);
    if (errors == 0) begin
      $display("multi_channel_bin_accumulator: match");
    end else begin
      $display("multi_channel_bin_accumulator: mismatch");
    end
    $finish;
  end

endmodule
